/* hdl/mpm_pkg.sv */
// Package: widths, constants and shared types for the 2x2 modular matrix power block.
`default_nettype none
package mpm_pkg;
  localparam int unsigned EntryBits = 32;
  localparam int unsigned ExpBits = 63;
  localparam int unsigned CntBits = $clog2(EntryBits + 1);
  localparam logic [EntryBits-1:0] ModulusReset = 32'd1000000007;

  typedef logic [EntryBits-1:0] entry_t;

  // request/response between sequencer and modular multiplier
  typedef struct packed {
    logic   go;
    entry_t a;
    entry_t b;
    entry_t c;   // addend, already reduced
  } mul_req_t;

  typedef struct packed {
    logic   done;
    entry_t res;
  } mul_rsp_t;
endpackage
`default_nettype wire

/* hdl/matrix_power_mod_2x2_top.sv */
// Top level: 2x2 matrix power modulo a programmable modulus.
// An item's time depends on the number of one bits in its exponent: a
// reduction pass over the 4 entries, then for each of the 63 exponent bits one
// squaring and, where the bit is one, one product into the result, each 8
// multiply-adds on the single bit-serial modular multiplier, the one shared
// unit that every multiply-add runs through. The result is shown with done_o
// for one cycle and stays on the outputs until the next item is taken; done_o
// is not held and the receiver cannot stall it. busy_o falls the cycle after
// done_o.
`default_nettype none
module matrix_power_mod_2x2_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] entry_top_left_i,
  input  logic [31:0] entry_top_right_i,
  input  logic [31:0] entry_bottom_left_i,
  input  logic [31:0] entry_bottom_right_i,
  input  logic [62:0] exponent_i,
  output logic        done_o,
  output logic [31:0] result_top_left_o,
  output logic [31:0] result_top_right_o,
  output logic [31:0] result_bottom_left_o,
  output logic [31:0] result_bottom_right_o
);
  import mpm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;  // reduce entries: 1*e+0 mod m
  localparam logic [2:0] S_MUL  = 3'd2;  // issue multiply
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [$clog2(ExpBits)-1:0] BitLast = ($clog2(ExpBits))'(ExpBits - 1);

  entry_t mod_q;
  logic [2:0] st_q, st_d;
  entry_t acc_q [4];
  entry_t run_q [4];
  entry_t nw_q [4];   // product being built
  entry_t part_q;     // first partial of an entry
  logic [ExpBits-1:0] exp_q;
  logic [$clog2(ExpBits)-1:0] bit_q;
  logic sq_q;        // 0: acc*run, 1: run*run
  logic [1:0] ent_q; // output entry
  logic half_q;      // which of the two terms
  logic red_q;       // reduction pass

  mul_req_t req;
  mul_rsp_t rsp;

  mpm_mulmod u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .mod_i(mod_q), .req_i(req), .rsp_o(rsp)
  );

  // operand selection for P*Q: r[i][j] = p[i][0]q[0][j] + p[i][1]q[1][j]
  entry_t pa, qb;
  logic [1:0] pi, qi;
  always_comb begin
    pi = {ent_q[1], half_q};
    qi = {half_q, ent_q[0]};
    pa = sq_q ? run_q[pi] : acc_q[pi];
    qb = run_q[qi];
  end

  logic one_mod;
  assign one_mod = (mod_q == 32'd1);

  always_comb begin
    st_d = st_q;
    req.go = 1'b0;
    req.a  = pa;
    req.b  = qb;
    req.c  = half_q ? part_q : '0;
    case (st_q)
      S_IDLE: if (start_i) st_d = S_RED;
      S_RED: begin
        // entry runs through the serial side so any entry value reduces fully
        req.go = 1'b1;
        req.a  = 32'd1;
        req.b  = run_q[ent_q];
        req.c  = '0;
        st_d   = S_WAIT;
      end
      S_MUL: begin
        req.go = 1'b1;
        st_d   = S_WAIT;
      end
      S_WAIT: begin
        if (rsp.done) begin
          if (red_q) st_d = (ent_q == 2'd3) ? S_MUL : S_RED;
          else if (half_q && ent_q == 2'd3 && sq_q && bit_q == BitLast) st_d = S_OUT;
          else st_d = S_MUL;
        end
      end
      S_OUT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      mod_q <= ModulusReset;
      red_q <= 1'b0;
      ent_q <= '0;
      half_q <= 1'b0;
      sq_q  <= 1'b0;
      bit_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) mod_q <= cfg_wdata_i;
      if (st_q == S_IDLE && start_i) begin
        red_q <= 1'b1; ent_q <= '0; half_q <= 1'b0; sq_q <= 1'b0; bit_q <= '0;
      end else if (st_q == S_WAIT && rsp.done) begin
        if (red_q) begin
          ent_q <= ent_q + 1'b1;
          if (ent_q == 2'd3) begin
            red_q <= 1'b0;
            sq_q  <= ~exp_q[0];
          end
        end else begin
          half_q <= ~half_q;
          if (half_q) begin
            ent_q <= ent_q + 1'b1;
            if (ent_q == 2'd3) begin
              if (!sq_q) sq_q <= 1'b1;
              else if (bit_q != BitLast) begin
                bit_q <= bit_q + 1'b1;
                sq_q  <= ~exp_q[bit_q + 1'b1];
              end
            end
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      run_q[0] <= entry_top_left_i;
      run_q[1] <= entry_top_right_i;
      run_q[2] <= entry_bottom_left_i;
      run_q[3] <= entry_bottom_right_i;
      acc_q[0] <= 32'd1; acc_q[1] <= '0; acc_q[2] <= '0; acc_q[3] <= 32'd1;
      exp_q <= exponent_i;
    end else if (st_q == S_WAIT && rsp.done) begin
      if (red_q) begin
        run_q[ent_q] <= rsp.res;
        if (ent_q == 2'd3 && one_mod) begin
          acc_q[0] <= '0; acc_q[3] <= '0;
        end
      end else if (!half_q) part_q <= rsp.res;
      else begin
        nw_q[ent_q] <= rsp.res;
        if (ent_q == 2'd3) begin
          if (sq_q) begin
            run_q[0] <= nw_q[0]; run_q[1] <= nw_q[1];
            run_q[2] <= nw_q[2]; run_q[3] <= rsp.res;
          end else begin
            acc_q[0] <= nw_q[0]; acc_q[1] <= nw_q[1];
            acc_q[2] <= nw_q[2]; acc_q[3] <= rsp.res;
          end
        end
      end
    end
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = (st_q == S_OUT);
  assign result_top_left_o     = acc_q[0];
  assign result_top_right_o    = acc_q[1];
  assign result_bottom_left_o  = acc_q[2];
  assign result_bottom_right_o = acc_q[3];
endmodule
`default_nettype wire

/* hdl/mpm_mulmod.sv */
// Bit-serial modular multiply-add: res = (a*b + c) mod m, one multiplier bit per cycle.
`default_nettype none
module mpm_mulmod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpm_pkg::entry_t   mod_i,
  input  mpm_pkg::mul_req_t req_i,
  output mpm_pkg::mul_rsp_t rsp_o
);
  import mpm_pkg::*;

  // a zero modulus means 2^32
  logic [EntryBits:0] m;
  assign m = (mod_i == '0) ? {1'b1, {EntryBits{1'b0}}} : {1'b0, mod_i};

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  entry_t             a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic               done_q, done_d;

  // reduce x < 2m to [0, m)
  function automatic entry_t red(input logic [EntryBits+1:0] x,
                                 input logic [EntryBits:0] mm);
    logic [EntryBits+1:0] t;
    begin
      t = x - {1'b0, mm};
      red = (x >= {1'b0, mm}) ? t[EntryBits-1:0] : x[EntryBits-1:0];
    end
  endfunction

  logic [EntryBits+1:0] dbl, sum;
  entry_t               dbl_r;

  // Horner step, msb of b first: acc = 2*acc (+ a)
  always_comb begin
    dbl   = {1'b0, acc_q, 1'b0};
    dbl_r = red(dbl, m);
    sum   = {2'b00, dbl_r} + {2'b00, a_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.go) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(EntryBits);
      a_d    = req_i.a;
      b_d    = req_i.b;
      // chain starts at zero; the addend goes in after the last step
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = b_q[EntryBits-1] ? red(sum, m) : dbl_r;
      b_d   = {b_q[EntryBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  entry_t c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    if (req_i.go) c_q <= req_i.c;
  end

  // final addend add, one compare-subtract
  assign rsp_o.done = done_q;
  assign rsp_o.res  = red({2'b00, acc_q} + {2'b00, c_q}, m);
endmodule
`default_nettype wire

/* hdl/mpm_checker.sv */
// Port-level checker for the matrix power block, bound to the top level.
`default_nettype none
module mpm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);
  // an accepted item makes the block busy
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("start not taken");
  // done ends the busy period
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("busy after done");
  // done only while busy
  a_dbusy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");
  // done is a single pulse
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
endmodule

bind matrix_power_mod_2x2_top mpm_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .done_o(done_o)
);
`default_nettype wire

/* sim/testbench.sv */
// Testbench for the 2x2 modular matrix power block: directed and random items against a predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mpm_pkg::*;

  typedef struct {
    logic [63:0] tl, tr, bl, br;
  } mat_t;

  typedef struct {
    entry_t tl, tr, bl, br;
  } power_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [31:0]          cfg_wdata;
  logic                 start;
  logic                 busy;
  entry_t               ent_tl, ent_tr, ent_bl, ent_br;
  logic [ExpBits-1:0]   expo;
  logic                 done;
  entry_t               res_tl, res_tr, res_bl, res_br;

  logic [31:0]          modulus_shadow;
  power_t               pending_powers[$];
  int unsigned          err_count;
  int unsigned          sender_idle_pct;

  matrix_power_mod_2x2_top u_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_wdata_i           (cfg_wdata),
    .start_i               (start),
    .busy_o                (busy),
    .entry_top_left_i      (ent_tl),
    .entry_top_right_i     (ent_tr),
    .entry_bottom_left_i   (ent_bl),
    .entry_bottom_right_i  (ent_br),
    .exponent_i            (expo),
    .done_o                (done),
    .result_top_left_o     (res_tl),
    .result_top_right_o    (res_tr),
    .result_bottom_left_o  (res_bl),
    .result_bottom_right_o (res_br)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // modular product and sum, operands below 2^32
  function automatic logic [63:0] mul_add_mod(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c, logic [63:0] d,
                                              logic [63:0] m);
    logic [63:0] p, q;
    p = (a * b) % m;
    q = (c * d) % m;
    return (p + q) % m;
  endfunction

  function automatic mat_t mat_mul_mod(mat_t p, mat_t q, logic [63:0] m);
    mat_t r;
    r.tl = mul_add_mod(p.tl, q.tl, p.tr, q.bl, m);
    r.tr = mul_add_mod(p.tl, q.tr, p.tr, q.br, m);
    r.bl = mul_add_mod(p.bl, q.tl, p.br, q.bl, m);
    r.br = mul_add_mod(p.bl, q.tr, p.br, q.br, m);
    return r;
  endfunction

  // square and multiply, least significant exponent bit first
  function automatic power_t predict_power(entry_t a, entry_t b, entry_t c, entry_t d,
                                           logic [ExpBits-1:0] e, logic [31:0] modreg);
    logic [63:0] m;
    mat_t acc, run;
    power_t p;
    m = (modreg == 32'd0) ? 64'h1_0000_0000 : {32'd0, modreg};
    run.tl = {32'd0, a} % m;
    run.tr = {32'd0, b} % m;
    run.bl = {32'd0, c} % m;
    run.br = {32'd0, d} % m;
    acc.tl = 64'd1 % m;
    acc.tr = 64'd0;
    acc.bl = 64'd0;
    acc.br = 64'd1 % m;
    for (int i = 0; i < ExpBits; i++) begin
      if (e[i]) acc = mat_mul_mod(acc, run, m);
      run = mat_mul_mod(run, run, m);
    end
    p.tl = acc.tl[31:0];
    p.tr = acc.tr[31:0];
    p.bl = acc.bl[31:0];
    p.br = acc.br[31:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // send one item, idling first at the current rate
  task automatic send_matrix(entry_t a, entry_t b, entry_t c, entry_t d,
                             logic [ExpBits-1:0] e);
    power_t predicted;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < sender_idle_pct) @(posedge clk);
    end
    start  <= 1'b1;
    ent_tl <= a;
    ent_tr <= b;
    ent_bl <= c;
    ent_br <= d;
    expo   <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_power(a, b, c, d, e, modulus_shadow);
    pending_powers = {pending_powers, predicted};
  endtask

  // let the block drain, then write the modulus
  task automatic write_modulus(logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_shadow = value;
  endtask

  function automatic entry_t rand_entry();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 3));
      3:       return $urandom;
      default: return (modulus_shadow == 32'd0) ? $urandom : $urandom % modulus_shadow;
    endcase
  endfunction

  function automatic logic [ExpBits-1:0] rand_exponent();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return ExpBits'($urandom_range(0, 40));
      1:       return w[ExpBits-1:0] >> $urandom_range(0, ExpBits - 1);
      default: return w[ExpBits-1:0];
    endcase
  endfunction

  // reset value of the modulus, zero and full exponents, unreduced entries
  task automatic test_reset_modulus();
    sender_idle_pct = 0;
    send_matrix(32'd1, 32'd1, 32'd1, 32'd0, 63'd0);
    send_matrix(32'd1, 32'd1, 32'd1, 32'd0, 63'd1);
    send_matrix(32'd1, 32'd1, 32'd1, 32'd0, 63'd90);
    send_matrix(32'd0, 32'd0, 32'd0, 32'd0, 63'd0);
    send_matrix(32'd0, 32'd0, 32'd0, 32'd0, {ExpBits{1'b1}});
    send_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                {ExpBits{1'b1}});
    send_matrix(32'd1000000006, 32'd1000000007, 32'd1000000008, 32'd2, 63'd5);
    send_matrix(32'd2, 32'd3, 32'd5, 32'd7, {1'b1, {(ExpBits-1){1'b0}}});
  endtask

  // extreme moduli: two, one, zero (wraps at 2^32), all ones
  task automatic test_modulus_extremes();
    logic [31:0] mods[4];
    mods = '{32'd2, 32'd1, 32'd0, 32'hFFFF_FFFF};
    foreach (mods[k]) begin
      write_modulus(mods[k]);
      send_matrix(32'd1, 32'd1, 32'd1, 32'd0, 63'd0);
      send_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd3, 32'hFFFF_FFFF, {ExpBits{1'b1}});
      send_matrix(32'd1, 32'd1, 32'd1, 32'd0, 63'd47);
    end
  endtask

  // random items over random moduli, with idle rates of 0, 52 and 26 percent
  task automatic test_random_items();
    int unsigned idle_rates[4];
    logic [31:0] m;
    idle_rates = '{0, 52, 0, 26};
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       m = $urandom_range(2, 20);
        1:       m = 32'd1000000007;
        default: m = $urandom;
      endcase
      write_modulus(m);
      sender_idle_pct = idle_rates[ph % 4];
      repeat (34) send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                              rand_exponent());
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    power_t want;
    if (rst_n && done) begin
      if (pending_powers.size() == 0) begin
        report_mismatch("unexpected result top_left", res_tl, 32'd0);
      end else begin
        want = pending_powers.pop_front();
        if (res_tl !== want.tl) report_mismatch("top_left", res_tl, want.tl);
        if (res_tr !== want.tr) report_mismatch("top_right", res_tr, want.tr);
        if (res_bl !== want.bl) report_mismatch("bottom_left", res_bl, want.bl);
        if (res_br !== want.br) report_mismatch("bottom_right", res_br, want.br);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 32'd0;
    start           = 1'b0;
    ent_tl          = 32'd0;
    ent_tr          = 32'd0;
    ent_bl          = 32'd0;
    ent_br          = 32'd0;
    expo            = '0;
    err_count       = 0;
    sender_idle_pct = 0;
    modulus_shadow  = ModulusReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_modulus();
    test_modulus_extremes();
    test_random_items();

    start <= 1'b0;
    @(posedge clk);
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog: stops a run that hangs
  initial begin
    #100ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
